// ----- rtl/core/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Shared command codes, status codes and the controller/datapath handshake
// structures.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    // Request command field.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_UP,
        OP_PLACE,
        OP_POP_LD,
        OP_DOWN,
        OP_RESULT
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic up_move;
        logic up_root;
        logic dn_move;
    } t_dp_stat;

endpackage

// ----- rtl/core/mhpq_if.sv -----
// ----------------------------------------------------------------------------
// Min-heap priority queue channel interfaces
// Request channel (command and value) and response channel (heap summary),
// both with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhpq_req_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [DATA_WIDTH-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface mhpq_rsp_if #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_WIDTH  = 7
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] top_value;
    logic                  top_valid;
    logic [CNT_WIDTH-1:0]  entry_total;
    logic [1:0]            status;

    modport source (output valid, output top_value, output top_valid,
                    output entry_total, output status, input ready);
    modport sink   (input valid, input top_value, input top_valid,
                    input entry_total, input status, output ready);
endinterface

// ----- rtl/core/min_heap_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// Min-heap priority queue core
// Binary min-heap of signed values with push and pop-minimum requests; each
// request returns the current minimum, its valid flag, the entry count and
// a status code.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                                         Handshake
//   i_req    in   command (0 push, 1 pop), value                  valid/ready
//   o_rsp    out  top_value, top_valid, entry_total, status       valid/ready
//
// One request is processed at a time. A push or pop walks at most
// log2(DEPTH) heap levels before its result is latched; a refused request
// goes straight to the result stage. The sift loops do one level per cycle
// through the two registered read ports and single write port of the heap
// store.
// Reset (synchronous, active low) empties the heap; the store holds no reset
// value and its words beyond the live entries are never used.
// A stalled response waits in the output register; the next request is
// taken once the current result has been latched into that register.
//
module min_heap_priority_queue_core
    import mhpq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mhpq_req_if.sink   i_req,
    mhpq_rsp_if.source o_rsp
);

    // The entry count must hold the depth itself.
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // The controller walks the request through its steps and holds the
    // response valid flag; the heap store and the response payload live in the datapath.
    mhpq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_req.valid),
        .i_in_command (i_req.command),
        .o_in_ready   (i_req.ready),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .i_stat       (dp_stat),
        .o_cmd        (dp_cmd)
    );

    // The datapath sifts the moving value through the store, tracks the
    // root in a shadow register and latches the response payload.
    mhpq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_WIDTH  (CNT_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_value       (i_req.value),
        .o_stat        (dp_stat),
        .o_top_value   (o_rsp.top_value),
        .o_top_valid   (o_rsp.top_valid),
        .o_entry_total (o_rsp.entry_total),
        .o_status      (o_rsp.status)
    );

endmodule

// ----- rtl/core/mhpq_datapath.sv -----
// ----------------------------------------------------------------------------
// Min-heap priority queue datapath
// Heap store, entry count, sift position and moving value, compare logic
// and the result register.
// ----------------------------------------------------------------------------
module mhpq_datapath
    import mhpq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    parameter int CNT_WIDTH  = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [DATA_WIDTH-1:0] i_value,
    output t_dp_stat              o_stat,
    output logic [DATA_WIDTH-1:0] o_top_value,
    output logic                  o_top_valid,
    output logic [CNT_WIDTH-1:0]  o_entry_total,
    output logic [1:0]            o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int KW = AW + 1;
    localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);
    localparam logic [KW-1:0]        K_ONE    = KW'(1);
    localparam logic [KW-1:0]        K_TWO    = KW'(2);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_a;
    logic [DATA_WIDTH-1:0] r_rd_b;
    logic [DATA_WIDTH-1:0] r_val;
    logic [DATA_WIDTH-1:0] r_top;
    logic [CNT_WIDTH-1:0]  r_count;
    logic [AW-1:0]         r_pos;

    logic [DATA_WIDTH-1:0] r_res_top;
    logic                  r_res_valid;
    logic [CNT_WIDTH-1:0]  r_res_total;
    logic [1:0]            r_res_status;

    logic [AW-1:0]         push_pos;
    logic [AW-1:0]         push_par;
    logic [AW-1:0]         par;
    logic [AW-1:0]         grand_par;
    logic                  up_move;
    logic [KW-1:0]         kid_l;
    logic [KW:0]           kid_r;
    logic                  left_ok;
    logic                  right_ok;
    logic                  pick_r;
    logic [DATA_WIDTH-1:0] child;
    logic [AW-1:0]         cidx;
    logic [KW-1:0]         ckid_l;
    logic [KW-1:0]         ckid_r;
    logic                  dn_move;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [AW-1:0]         rd_addr_a;
    logic [AW-1:0]         rd_addr_b;

    // Sift-up: the value in flight sits at r_pos, r_rd_a holds its parent.
    assign push_pos  = r_count[AW-1:0];
    assign push_par  = (push_pos - AW'(1)) >> 1;
    assign par       = (r_pos - AW'(1)) >> 1;
    assign grand_par = (par - AW'(1)) >> 1;
    assign up_move   = $signed(r_val) < $signed(r_rd_a);

    // Sift-down: r_rd_a and r_rd_b hold the left and right children of r_pos.
    assign kid_l    = {r_pos, 1'b1};
    assign kid_r    = {1'b0, kid_l} + (KW + 1)'(1);
    assign left_ok  = kid_l < KW'(r_count);
    assign right_ok = kid_r < (KW + 1)'(r_count);
    assign pick_r   = right_ok && ($signed(r_rd_b) < $signed(r_rd_a));
    assign child    = pick_r ? r_rd_b : r_rd_a;
    assign cidx     = pick_r ? kid_r[AW-1:0] : kid_l[AW-1:0];
    assign dn_move  = left_ok && ($signed(child) < $signed(r_val));
    assign ckid_l   = {cidx, 1'b1};
    assign ckid_r   = ckid_l + K_ONE;

    assign o_stat.full    = (r_count == CNT_FULL);
    assign o_stat.empty   = (r_count == '0);
    assign o_stat.up_move = up_move;
    assign o_stat.up_root = (par == '0);
    assign o_stat.dn_move = dn_move;

    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_val;
        rd_addr_a = '0;
        rd_addr_b = '0;
        unique case (i_cmd.op)
            OP_PUSH: begin
                rd_addr_a = push_par;
            end
            OP_POP: begin
                rd_addr_a = AW'(r_count - CNT_WIDTH'(1));
            end
            OP_UP: begin
                wr_en     = 1'b1;
                wr_data   = up_move ? r_rd_a : r_val;
                rd_addr_a = grand_par;
            end
            OP_PLACE: begin
                wr_en = 1'b1;
            end
            OP_POP_LD: begin
                rd_addr_a = K_ONE[AW-1:0];
                rd_addr_b = K_TWO[AW-1:0];
            end
            OP_DOWN: begin
                wr_en     = 1'b1;
                wr_data   = dn_move ? child : r_val;
                rd_addr_a = ckid_l[AW-1:0];
                rd_addr_b = ckid_r[AW-1:0];
            end
            OP_NONE, OP_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    // Heap store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // The root is mirrored in r_top on every write to address zero.
    always_ff @(posedge i_clk) begin
        if (wr_en && (wr_addr == '0)) begin
            r_top <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.op == OP_PUSH) begin
            r_count <= r_count + CNT_WIDTH'(1);
        end else if (i_cmd.op == OP_POP) begin
            r_count <= r_count - CNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_PUSH: begin
                r_val <= i_value;
                r_pos <= push_pos;
            end
            OP_POP_LD: begin
                r_val <= r_rd_a;
                r_pos <= '0;
            end
            OP_UP: begin
                if (up_move) begin
                    r_pos <= par;
                end
            end
            OP_DOWN: begin
                if (dn_move) begin
                    r_pos <= cidx;
                end
            end
            OP_NONE, OP_POP, OP_PLACE, OP_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_RESULT) begin
            r_res_valid  <= (r_count != '0);
            r_res_top    <= (r_count != '0) ? r_top : '0;
            r_res_total  <= r_count;
            r_res_status <= i_cmd.code;
        end
    end

    assign o_top_value   = r_res_top;
    assign o_top_valid   = r_res_valid;
    assign o_entry_total = r_res_total;
    assign o_status      = r_res_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count exceeds the store depth");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (CNT_WIDTH'(wr_addr) < r_count))
        else $error("store written outside the live heap");

    a_result_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_RESULT) |=> (r_res_valid == (r_res_total != '0)))
        else $error("result valid flag disagrees with entry total");

endmodule

// ----- rtl/core/mhpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Min-heap priority queue controller
// Sequences push, pop and the sift loops, and owns the result valid flag.
// ----------------------------------------------------------------------------
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_command,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP     = 3'd1;
    localparam logic [2:0] S_PLACE  = 3'd2;
    localparam logic [2:0] S_POP_LD = 3'd3;
    localparam logic [2:0] S_DOWN   = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_status    r_code;
    t_status    n_code;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = (r_state == S_IDLE) && i_in_valid;

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = OP_NONE;
        o_cmd.code  = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_code = ST_OK;
                    if (i_in_command == CMD_PUSH) begin
                        if (i_stat.full) begin
                            n_code  = ST_FULL;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.op = OP_PUSH;
                            n_state  = i_stat.empty ? S_PLACE : S_UP;
                        end
                    end else begin
                        if (i_stat.empty) begin
                            n_code  = ST_EMPTY;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.op = OP_POP;
                            n_state  = S_POP_LD;
                        end
                    end
                end
            end
            S_UP: begin
                o_cmd.op = OP_UP;
                if (!i_stat.up_move) begin
                    n_state = S_FIN;
                end else if (i_stat.up_root) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.op = OP_PLACE;
                n_state  = S_FIN;
            end
            S_POP_LD: begin
                if (i_stat.empty) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = OP_POP_LD;
                    n_state  = S_DOWN;
                end
            end
            S_DOWN: begin
                o_cmd.op = OP_DOWN;
                if (!i_stat.dn_move) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_RESULT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_code      <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in_command == CMD_PUSH) && i_stat.full)
        |=> (r_state == S_FIN) && (r_code == ST_FULL))
        else $error("push to a full heap not refused");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in_command == CMD_POP) && i_stat.empty)
        |=> (r_state == S_FIN) && (r_code == ST_EMPTY))
        else $error("pop from an empty heap not refused");

    a_down_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DOWN) && !i_stat.dn_move) |=> (r_state == S_FIN))
        else $error("sift-down did not finish when no child was smaller");

endmodule

// ----- test/tb_min_heap_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// Min-heap priority queue core testbench
// A table of directed requests is sent first: the value extremes, an empty
// pop, equal keys and a full drain. Random push/pop phases follow. These
// phases fill the heap past full, drain it past empty and mix the two.
// Every response is checked against an in-bench mirror of the heap or a
// directed row's fixed summary. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_min_heap_priority_queue_core;
    import mhpq_pkg::*;

    localparam int HEAP_DEPTH   = 64;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = 7;
    localparam int RANDOM_ITEMS = 1700;
    localparam int DIRECTED_N   = 25;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DATA_W-1:0] top_value;
        logic              top_valid;
        logic [CNT_W-1:0]  entry_total;
        t_status           status;
    } t_heap_summary;

    // One directed request. When fixed is set, the response is checked
    // against want. Otherwise it is checked against the heap mirror.
    typedef struct packed {
        logic              cmd;
        logic [DATA_W-1:0] value;
        logic              fixed;
        t_heap_summary     want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    mhpq_req_if #(.DATA_WIDTH(DATA_W))                  req_ch ();
    mhpq_rsp_if #(.DATA_WIDTH(DATA_W), .CNT_WIDTH(CNT_W)) rsp_ch ();

    min_heap_priority_queue_core #(
        .DEPTH      (HEAP_DEPTH),
        .DATA_WIDTH (DATA_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Mirror of the heap, kept in step with each accepted request.
    logic signed [DATA_W-1:0] mirror_heap [HEAP_DEPTH];
    int                       mirror_count;
    t_heap_summary            pending_summaries [$];
    int                       mismatch_count;
    bit                       calm_sender;

    t_stim_row directed_rows [DIRECTED_N] = '{
        '{CMD_POP,  32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 7'd0, ST_EMPTY}},
        '{CMD_PUSH, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1'b1, 7'd1, ST_OK}},
        '{CMD_PUSH, 32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b1, 7'd2, ST_OK}},
        '{CMD_PUSH, 32'h0000_0000, 1'b1, '{32'h8000_0000, 1'b1, 7'd3, ST_OK}},
        '{CMD_PUSH, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, 1'b1, 7'd4, ST_OK}},
        '{CMD_POP,  32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1, 7'd3, ST_OK}},
        '{CMD_POP,  32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 7'd2, ST_OK}},
        '{CMD_POP,  32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b1, 7'd1, ST_OK}},
        '{CMD_POP,  32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 7'd0, ST_OK}},
        '{CMD_POP,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 7'd0, ST_EMPTY}},
        // Equal keys: sifting has to stop on a tie.
        '{CMD_PUSH, 32'h0000_0005, 1'b1, '{32'h0000_0005, 1'b1, 7'd1, ST_OK}},
        '{CMD_PUSH, 32'h0000_0005, 1'b1, '{32'h0000_0005, 1'b1, 7'd2, ST_OK}},
        '{CMD_PUSH, 32'h0000_0005, 1'b1, '{32'h0000_0005, 1'b1, 7'd3, ST_OK}},
        '{CMD_PUSH, 32'h0000_0003, 1'b1, '{32'h0000_0003, 1'b1, 7'd4, ST_OK}},
        '{CMD_PUSH, 32'h0000_0003, 1'b1, '{32'h0000_0003, 1'b1, 7'd5, ST_OK}},
        '{CMD_PUSH, 32'h0000_0009, 1'b0, '0},
        '{CMD_PUSH, 32'h0000_0001, 1'b0, '0},
        '{CMD_POP,  32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_POP,  32'h0000_0000, 1'b0, '0},
        '{CMD_PUSH, 32'hAAAA_AAAA, 1'b0, '0},
        '{CMD_PUSH, 32'h5555_5555, 1'b0, '0},
        '{CMD_POP,  32'h5555_5555, 1'b0, '0},
        '{CMD_POP,  32'hAAAA_AAAA, 1'b0, '0},
        '{CMD_POP,  32'h0000_0000, 1'b0, '0},
        '{CMD_POP,  32'hFFFF_FFFF, 1'b0, '0}
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("tb_min_heap_priority_queue_core: FAIL");
        $finish;
    end

    // Applies one request to the mirror and returns the summary it yields.
    function automatic t_heap_summary mirror_heap_op(logic cmd, logic [DATA_W-1:0] val);
        t_heap_summary            s;
        int                       pos;
        int                       parent;
        int                       kid;
        logic signed [DATA_W-1:0] tmp;
        bit                       moving;
        s.status = ST_OK;
        if (cmd == CMD_PUSH) begin
            if (mirror_count >= HEAP_DEPTH) begin
                s.status = ST_FULL;
            end else begin
                pos = mirror_count;
                mirror_heap[pos] = val;
                mirror_count++;
                moving = 1'b1;
                while (moving && pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (mirror_heap[pos] < mirror_heap[parent]) begin
                        tmp = mirror_heap[pos];
                        mirror_heap[pos] = mirror_heap[parent];
                        mirror_heap[parent] = tmp;
                        pos = parent;
                    end else begin
                        moving = 1'b0;
                    end
                end
            end
        end else begin
            if (mirror_count == 0) begin
                s.status = ST_EMPTY;
            end else begin
                mirror_count--;
                mirror_heap[0] = mirror_heap[mirror_count];
                pos = 0;
                moving = 1'b1;
                while (moving) begin
                    kid = 2 * pos + 1;
                    if (kid >= mirror_count) begin
                        moving = 1'b0;
                    end else begin
                        // On a tie between the children the left one is taken.
                        if (kid + 1 < mirror_count && mirror_heap[kid + 1] < mirror_heap[kid])
                            kid++;
                        if (mirror_heap[kid] < mirror_heap[pos]) begin
                            tmp = mirror_heap[pos];
                            mirror_heap[pos] = mirror_heap[kid];
                            mirror_heap[kid] = tmp;
                            pos = kid;
                        end else begin
                            moving = 1'b0;
                        end
                    end
                end
            end
        end
        s.top_valid   = (mirror_count > 0);
        s.top_value   = (mirror_count > 0) ? mirror_heap[0] : '0;
        s.entry_total = mirror_count[CNT_W-1:0];
        return s;
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int pick_idle(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            return 0;
        else if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Value mix: fully random, small keys for ties, and the extremes.
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom;
        else if (r < 8)
            return $urandom_range(0, 8) - 4;
        else if (r == 8)
            return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
    endfunction

    // Sends one request and records its expected summary at the edge where
    // it is accepted. A fixed row overrides the mirror's prediction but still
    // advances the mirror.
    task automatic send_request(logic cmd, logic [DATA_W-1:0] val,
                                logic fixed, t_heap_summary want);
        int            gap;
        t_heap_summary s;
        gap = pick_idle(calm_sender);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.value   <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        s = mirror_heap_op(cmd, val);
        pending_summaries.push_back(fixed ? want : s);
    endtask

    // Response stalls: ready is held high for a while, then dropped for a
    // random gap. Occasionally there is a long stretch with no stall.
    initial begin
        int hold;
        int gap;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 8);
            rsp_ch.ready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            gap = pick_idle(1'b0);
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_heap_summary got;
        t_heap_summary exp_s;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.top_value   = rsp_ch.top_value;
            got.top_valid   = rsp_ch.top_valid;
            got.entry_total = rsp_ch.entry_total;
            got.status      = t_status'(rsp_ch.status);
            if (pending_summaries.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected response: top=%h valid=%b total=%0d status=%0d",
                             got.top_value, got.top_valid, got.entry_total, got.status);
            end else begin
                exp_s = pending_summaries.pop_front();
                if (got.top_value !== exp_s.top_value || got.top_valid !== exp_s.top_valid ||
                    got.entry_total !== exp_s.entry_total || got.status !== exp_s.status) begin
                    mismatch_count++;
                    // Fields in order: top value, valid, entry total, status.
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: exp %h/%b/%0d/%0d got %h/%b/%0d/%0d",
                                 exp_s.top_value, exp_s.top_valid, exp_s.entry_total,
                                 exp_s.status, got.top_value, got.top_valid,
                                 got.entry_total, got.status);
                end
            end
        end
    end

    initial begin
        int            sent;
        int            phase;
        int            span;
        int            overrun;
        logic          cmd;
        t_heap_summary none;
        none           = '0;
        sent           = 0;
        mirror_count   = 0;
        mismatch_count = 0;
        calm_sender    = 1'b0;
        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.command <= CMD_PUSH;
        req_ch.value   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_request(directed_rows[k].cmd, directed_rows[k].value,
                         directed_rows[k].fixed, directed_rows[k].want);

        // Random phases. A fill phase runs until the heap is full and then
        // pushes a few more times. A drain phase does the same at empty. A
        // mixed phase wanders around the middle.
        while (sent < RANDOM_ITEMS) begin
            phase       = $urandom_range(0, 2);
            calm_sender = ($urandom_range(0, 4) == 0);
            if (phase == 2) begin
                span = $urandom_range(20, 120);
                repeat (span) begin
                    cmd = ($urandom_range(0, 1) != 0) ? CMD_POP : CMD_PUSH;
                    send_request(cmd, pick_value(), 1'b0, none);
                    sent++;
                end
            end else begin
                overrun = $urandom_range(1, 4);
                while (overrun > 0) begin
                    if (phase == 0)
                        cmd = ($urandom_range(0, 9) == 0) ? CMD_POP : CMD_PUSH;
                    else
                        cmd = ($urandom_range(0, 9) == 0) ? CMD_PUSH : CMD_POP;
                    send_request(cmd, pick_value(), 1'b0, none);
                    sent++;
                    if ((phase == 0 && mirror_count == HEAP_DEPTH) ||
                        (phase == 1 && mirror_count == 0))
                        overrun--;
                end
            end
        end
        req_ch.valid <= 1'b0;

        while (pending_summaries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_summaries.size() == 0)
            $display("tb_min_heap_priority_queue_core: PASS");
        else
            $display("tb_min_heap_priority_queue_core: FAIL");
        $finish;
    end

endmodule
